// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; every user module has clk and rst (sync, active high).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FSPL_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fspl: property violated");
`define FSPL_NEVER(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("fspl: forbidden condition seen");
`else
`define FSPL_ASSERT(name, prop)
`define FSPL_NEVER(name, expr)
`endif
`endif

// ----- hw/rtl/fspl_pkg.sv -----
`default_nettype none
package fspl_pkg;

  // feedback pulse timing
  localparam int TIME_BITS  = 12;
  localparam int PERIOD_W   = TIME_BITS + 1;
  localparam int NUM_W      = TIME_BITS + 10;  // holds 1000 * high_time
  localparam int WIN_W      = (PERIOD_W > 12) ? PERIOD_W : 12;

  // field widths
  localparam int ANGLE_W    = 9;
  localparam int DUTY_W     = 10;
  localparam int DRIVE_W    = 8;
  localparam int PMIN_W     = 12;
  localparam int PROD2_W    = 19;  // (duty - duty_min) * 360 for the divided case
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // arithmetic constants
  localparam int DUTY_SCALE = 1000;
  localparam int ANGLE_SPAN = 360;
  localparam int ANGLE_MAX  = 359;
  localparam int ERR_HALF   = 180;
  localparam int DRIVE_STOP = 90;
  localparam int DRIVE_MAX  = 180;
  localparam int DEN_BIAS   = 10;

  // divider: 10 quotient bits, two per cycle
  localparam int DIV_QBITS  = 10;
  localparam int DIV_STEPS  = DIV_QBITS / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // register reset values
  localparam int RST_TARGET_ANGLE = 0;
  localparam int RST_PERIOD_MIN   = 1000;
  localparam int RST_PERIOD_MAX   = 1200;
  localparam int RST_DUTY_MIN     = 29;
  localparam int RST_DUTY_MAX     = 971;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_ANGLE = 3'd0,
    REG_PERIOD_MIN   = 3'd1,
    REG_PERIOD_MAX   = 3'd2,
    REG_DUTY_MIN     = 3'd3,
    REG_DUTY_MAX     = 3'd4
  } fspl_reg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] target_angle;
    logic [PMIN_W-1:0]  period_min;
    logic [PMIN_W-1:0]  period_max;
    logic [DUTY_W-1:0]  duty_min;
    logic [DUTY_W-1:0]  duty_max;
  } fspl_cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] high;
    logic [PERIOD_W-1:0]  period;
  } fspl_item_t;

  typedef struct packed {
    logic                start;
    logic [NUM_W-1:0]    dividend;
    logic [PERIOD_W-1:0] divisor;
  } fspl_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QBITS-1:0] quotient;
  } fspl_div_rsp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ST1,
    B_W1,
    B_PREP,
    B_ST2,
    B_W2,
    B_FIN
  } fspl_bstate_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fspl_front.sv -----
`default_nettype none
module fspl_front (
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [fspl_pkg::TIME_BITS-1:0] high_time,
  input  wire logic [fspl_pkg::TIME_BITS-1:0] low_time,
  input  wire fspl_pkg::fspl_cfg_t            cfg,
  input  wire logic                           fifo_full,
  output logic                                push,
  output fspl_pkg::fspl_item_t                item
);

  logic [fspl_pkg::PERIOD_W-1:0] period;
  logic [fspl_pkg::WIN_W-1:0]    period_x;
  logic                          keep;

  assign period   = fspl_pkg::PERIOD_W'(high_time) + fspl_pkg::PERIOD_W'(low_time);
  assign period_x = fspl_pkg::WIN_W'(period);

  // open window; a zero period never passes
  assign keep = (period != '0)
             && (period_x > fspl_pkg::WIN_W'(cfg.period_min))
             && (period_x < fspl_pkg::WIN_W'(cfg.period_max));

  assign in_stall    = fifo_full;
  assign push        = in_valid && !fifo_full && keep;
  assign item.high   = high_time;
  assign item.period = period;

endmodule
`default_nettype wire

// ----- hw/rtl/fspl_fifo.sv -----
`default_nettype none
`include "assert_macros.svh"
module fspl_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire fspl_pkg::fspl_item_t wr_item,
  input  wire logic                 pop,
  output fspl_pkg::fspl_item_t      head,
  output logic                      full,
  output logic                      empty
);

  fspl_pkg::fspl_item_t               mem [fspl_pkg::FIFO_DEPTH];
  logic [fspl_pkg::FIFO_AW-1:0]       wr_ptr;
  logic [fspl_pkg::FIFO_AW-1:0]       rd_ptr;
  logic [fspl_pkg::FIFO_AW:0]         count;

  assign full  = (count == (fspl_pkg::FIFO_AW + 1)'(fspl_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_item;
  end

  `FSPL_NEVER(a_fifo_no_overflow, push && full)
  `FSPL_NEVER(a_fifo_no_underflow, pop && empty)

endmodule
`default_nettype wire

// ----- hw/rtl/fspl_div.sv -----
`default_nettype none
module fspl_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire fspl_pkg::fspl_div_req_t req,
  output fspl_pkg::fspl_div_rsp_t      rsp
);

  // Restoring division, two quotient bits per cycle.
  // Caller guarantees dividend < divisor * 2^DIV_QBITS.
  logic                              busy;
  logic                              done;
  logic [fspl_pkg::DIV_CNT_W-1:0]    cnt;
  logic [fspl_pkg::NUM_W-1:0]        rem;
  logic [fspl_pkg::NUM_W-1:0]        dvs;
  logic [fspl_pkg::DIV_QBITS-1:0]    quo;

  logic                              ge_a, ge_b;
  logic [fspl_pkg::NUM_W-1:0]        rem_a, rem_b, dvs_b;

  always_comb begin
    ge_a  = (rem >= dvs);
    rem_a = ge_a ? (rem - dvs) : rem;
    dvs_b = dvs >> 1;
    ge_b  = (rem_a >= dvs_b);
    rem_b = ge_b ? (rem_a - dvs_b) : rem_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == fspl_pkg::DIV_CNT_W'(fspl_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend;
      dvs <= fspl_pkg::NUM_W'(req.divisor) << (fspl_pkg::DIV_QBITS - 1);
      quo <= '0;
    end else if (busy) begin
      rem <= rem_b;
      dvs <= dvs >> 2;
      quo <= {quo[fspl_pkg::DIV_QBITS-3:0], ge_a, ge_b};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

// ----- hw/rtl/fspl_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module fspl_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire fspl_pkg::fspl_cfg_t          cfg,
  input  wire logic                         fifo_empty,
  input  wire fspl_pkg::fspl_item_t         fifo_head,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [fspl_pkg::DRIVE_W-1:0]      drive,
  output logic [fspl_pkg::ANGLE_W-1:0]      measured_angle,
  output logic signed [fspl_pkg::ANGLE_W-1:0] angle_error
);

  fspl_pkg::fspl_bstate_t state, state_next;
  fspl_pkg::fspl_div_req_t div_req;
  fspl_pkg::fspl_div_rsp_t div_rsp;

  logic [fspl_pkg::NUM_W-1:0]     num_reg;
  logic [fspl_pkg::PERIOD_W-1:0]  dvs_reg;
  logic [fspl_pkg::DUTY_W-1:0]    duty;
  logic [fspl_pkg::ANGLE_W-1:0]   angle_reg;

  logic                           load_out;
  logic [fspl_pkg::NUM_W-1:0]     num1;

  // angle stage
  logic signed [11:0]             diff, den;
  logic                           special;
  logic [fspl_pkg::ANGLE_W-1:0]   angle_sp;
  logic [fspl_pkg::PROD2_W-1:0]   prod2;

  // error / drive stage
  logic signed [10:0]             err_raw, err_w, drv;
  logic [fspl_pkg::DRIVE_W-1:0]   drive_sat;

  fspl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign num1 = fspl_pkg::NUM_W'(fifo_head.high) * fspl_pkg::NUM_W'(fspl_pkg::DUTY_SCALE);

  always_comb begin
    diff = $signed({2'b00, duty}) - $signed({2'b00, cfg.duty_min});
    den  = $signed({2'b00, cfg.duty_max}) - $signed({2'b00, cfg.duty_min})
         + $signed(12'(fspl_pkg::DEN_BIAS));
    // no division when the result is fixed: bad range, at or below zero, or at or past a full turn
    special  = (den <= 12'sd0) || (diff <= 12'sd0) || (diff >= den);
    angle_sp = ((den > 12'sd0) && (diff > 12'sd0)) ? fspl_pkg::ANGLE_W'(fspl_pkg::ANGLE_MAX)
                                                   : '0;
    prod2    = fspl_pkg::PROD2_W'(diff[10:0]) * fspl_pkg::PROD2_W'(fspl_pkg::ANGLE_SPAN);
  end

  always_comb begin
    err_raw = $signed({2'b00, cfg.target_angle}) - $signed({2'b00, angle_reg});
    if (err_raw > $signed(11'(fspl_pkg::ERR_HALF))) begin
      err_w = err_raw - $signed(11'(fspl_pkg::ANGLE_SPAN));
    end else if (err_raw < -$signed(11'(fspl_pkg::ERR_HALF))) begin
      err_w = err_raw + $signed(11'(fspl_pkg::ANGLE_SPAN));
    end else begin
      err_w = err_raw;
    end
    drv = $signed(11'(fspl_pkg::DRIVE_STOP)) - err_w;
    if (drv < 11'sd0) begin
      drive_sat = '0;
    end else if (drv > $signed(11'(fspl_pkg::DRIVE_MAX))) begin
      drive_sat = fspl_pkg::DRIVE_W'(fspl_pkg::DRIVE_MAX);
    end else begin
      drive_sat = drv[fspl_pkg::DRIVE_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fspl_pkg::B_IDLE: if (!fifo_empty) state_next = fspl_pkg::B_ST1;
      fspl_pkg::B_ST1:  state_next = fspl_pkg::B_W1;
      fspl_pkg::B_W1:   if (div_rsp.done) state_next = fspl_pkg::B_PREP;
      fspl_pkg::B_PREP: state_next = special ? fspl_pkg::B_FIN : fspl_pkg::B_ST2;
      fspl_pkg::B_ST2:  state_next = fspl_pkg::B_W2;
      fspl_pkg::B_W2:   if (div_rsp.done) state_next = fspl_pkg::B_FIN;
      fspl_pkg::B_FIN:  if (!out_valid || !out_stall) state_next = fspl_pkg::B_IDLE;
      default:          state_next = fspl_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop              = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = num_reg;
    div_req.divisor  = dvs_reg;
    case (state)
      fspl_pkg::B_IDLE: pop = !fifo_empty;
      fspl_pkg::B_ST1,
      fspl_pkg::B_ST2:  div_req.start = 1'b1;
      fspl_pkg::B_FIN:  load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fspl_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out)        out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      num_reg <= num1;
      dvs_reg <= fifo_head.period;
    end
    if (state == fspl_pkg::B_W1 && div_rsp.done) duty <= div_rsp.quotient;
    if (state == fspl_pkg::B_PREP) begin
      num_reg   <= fspl_pkg::NUM_W'(prod2);
      dvs_reg   <= fspl_pkg::PERIOD_W'(den[10:0]);
      angle_reg <= angle_sp;
    end
    if (state == fspl_pkg::B_W2 && div_rsp.done) begin
      angle_reg <= div_rsp.quotient[fspl_pkg::ANGLE_W-1:0];
    end
    if (load_out) begin
      drive          <= drive_sat;
      measured_angle <= angle_reg;
      angle_error    <= err_w[fspl_pkg::ANGLE_W-1:0];
    end
  end

  `FSPL_ASSERT(a_div_done_in_wait, div_rsp.done |-> (state == fspl_pkg::B_W1 || state == fspl_pkg::B_W2))
  `FSPL_ASSERT(a_fin_loads_out, (state == fspl_pkg::B_FIN && !(out_valid && out_stall)) |=> out_valid)
  `FSPL_ASSERT(a_out_in_range, out_valid |-> (drive <= 8'(fspl_pkg::DRIVE_MAX) && measured_angle <= 9'(fspl_pkg::ANGLE_MAX)))

endmodule
`default_nettype wire

// ----- hw/rtl/feedback_servo_position_loop_core.sv -----
`default_nettype none
// Position loop for a continuous-rotation servo with PWM angle feedback. Each
// input word is one measured feedback pulse (high and low time in us). Pulses
// whose period is zero or not strictly inside (period_min, period_max) are
// dropped with no output word. For the rest the core forms duty in per-mille,
// floor(1000*high/period), maps it to a shaft angle (duty-duty_min)*360 /
// (duty_max-duty_min+10) clamped to 0..359, wraps target-angle into
// -180..180 and emits drive = 90 - error saturated to 0..180 (90 = stop),
// along with the angle and the error. In the back end a kept pulse makes
// two passes through one shared restoring divider that retires two quotient
// bits per cycle, plus pop, setup and output load; pulses whose angle comes
// out clamped skip the second pass. A 2-entry queue sits between the window
// check and the arithmetic, and the result sits in an output register, so
// input is taken while the back end works and while a result waits, until
// the queue is full. Registers (index: target_angle 0, period_min 1,
// period_max 2, duty_min 3, duty_max 4) are to be written by the user only
// while idle; the core does not enforce this, and cfg_ready is always high.
module feedback_servo_position_loop_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // pulse input
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [fspl_pkg::TIME_BITS-1:0]         high_time,
  input  wire logic [fspl_pkg::TIME_BITS-1:0]         low_time,
  // result output
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [fspl_pkg::DRIVE_W-1:0]                drive,
  output logic [fspl_pkg::ANGLE_W-1:0]                measured_angle,
  output logic signed [fspl_pkg::ANGLE_W-1:0]         angle_error,
  // register writes
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [fspl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [fspl_pkg::CFG_DATA_W-1:0]        cfg_data
);

  fspl_pkg::fspl_cfg_t  cfg;
  fspl_pkg::fspl_item_t push_item;
  fspl_pkg::fspl_item_t head_item;
  logic                 push, pop, fifo_full, fifo_empty;

  // config is always accepted; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_angle <= fspl_pkg::ANGLE_W'(fspl_pkg::RST_TARGET_ANGLE);
      cfg.period_min   <= fspl_pkg::PMIN_W'(fspl_pkg::RST_PERIOD_MIN);
      cfg.period_max   <= fspl_pkg::PMIN_W'(fspl_pkg::RST_PERIOD_MAX);
      cfg.duty_min     <= fspl_pkg::DUTY_W'(fspl_pkg::RST_DUTY_MIN);
      cfg.duty_max     <= fspl_pkg::DUTY_W'(fspl_pkg::RST_DUTY_MAX);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fspl_pkg::REG_TARGET_ANGLE: cfg.target_angle <= cfg_data[fspl_pkg::ANGLE_W-1:0];
        fspl_pkg::REG_PERIOD_MIN:   cfg.period_min   <= cfg_data[fspl_pkg::PMIN_W-1:0];
        fspl_pkg::REG_PERIOD_MAX:   cfg.period_max   <= cfg_data[fspl_pkg::PMIN_W-1:0];
        fspl_pkg::REG_DUTY_MIN:     cfg.duty_min     <= cfg_data[fspl_pkg::DUTY_W-1:0];
        fspl_pkg::REG_DUTY_MAX:     cfg.duty_max     <= cfg_data[fspl_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // front: period and window check, queue only kept pulses
  fspl_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .high_time (high_time),
    .low_time  (low_time),
    .cfg       (cfg),
    .fifo_full (fifo_full),
    .push      (push),
    .item      (push_item)
  );

  fspl_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (push_item),
    .pop     (pop),
    .head    (head_item),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  // back: duty, angle, error and drive, one pulse at a time
  fspl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .fifo_empty     (fifo_empty),
    .fifo_head      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive          (drive),
    .measured_angle (measured_angle),
    .angle_error    (angle_error)
  );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fspl_pkg::*;

  // Generous: ~1700 words under heavy stall, plus drain time before every
  // register change.
  localparam int CYCLE_LIMIT    = 600_000;
  localparam int SETTLE_CYC     = 60;   // covers the back end, the queue and the output reg
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_BLOCKS   = 6;
  localparam int PULSES_PER_BLK = 94;   // 3 phases x 6 blocks x 94 ~ 1700 words

  // one expected output word
  typedef struct packed {
    logic [DRIVE_W-1:0]        drive;
    logic [ANGLE_W-1:0]        angle;
    logic signed [ANGLE_W-1:0] err;
  } servo_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_BITS-1:0] high_time = '0;
  logic [TIME_BITS-1:0] low_time = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [DRIVE_W-1:0]        drive;
  logic [ANGLE_W-1:0]        measured_angle;
  logic signed [ANGLE_W-1:0] angle_error;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  feedback_servo_position_loop_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .high_time      (high_time),
    .low_time       (low_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive          (drive),
    .measured_angle (measured_angle),
    .angle_error    (angle_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Shadow copy of the register file, updated on each accepted write.
  logic [ANGLE_W-1:0] loop_target = ANGLE_W'(RST_TARGET_ANGLE);
  logic [PMIN_W-1:0]  win_lo      = PMIN_W'(RST_PERIOD_MIN);
  logic [PMIN_W-1:0]  win_hi      = PMIN_W'(RST_PERIOD_MAX);
  logic [DUTY_W-1:0]  duty_lo     = DUTY_W'(RST_DUTY_MIN);
  logic [DUTY_W-1:0]  duty_hi     = DUTY_W'(RST_DUTY_MAX);

  servo_cmd_t pending_cmds[$];  // commands owed by the DUT, oldest first

  int cycle_count   = 0;
  int gap_pct       = 0;  // chance (%) the sender idles before a word
  int stall_pct     = 0;  // chance (%) the receiver stalls on a cycle
  int pulses_sent   = 0;
  int kept_pulses   = 0;
  int cmds_checked  = 0;
  int mismatches    = 0;
  int orphan_cmds   = 0;
  int settings_done = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: any hang (lost word, stuck stall) ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands still owed",
               cycle_count, pending_cmds.size());
      $display("feedback_servo_position_loop_core verification failed");
      $finish;
    end
  end

  // Receiver back-pressure, one fresh coin per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Predict the command for one pulse. Returns 0 when the pulse is dropped.
  function automatic bit servo_command_of(input logic [TIME_BITS-1:0] hi_us,
                                          input logic [TIME_BITS-1:0] lo_us,
                                          output servo_cmd_t cmd);
    int period;
    int duty;
    int den;
    int ang;
    int err;
    int drv;
    cmd = '0;
    period = int'(hi_us) + int'(lo_us);
    // zero period always drops; window bounds are exclusive
    if (period == 0 || period <= int'(win_lo) || period >= int'(win_hi))
      return 1'b0;
    duty = (DUTY_SCALE * int'(hi_us)) / period;
    den  = int'(duty_hi) - int'(duty_lo) + DEN_BIAS;
    if (den <= 0) begin
      ang = 0;  // inverted duty registers: angle pinned at zero
    end else begin
      // SV integer division truncates toward zero, same as the spec
      ang = ((duty - int'(duty_lo)) * ANGLE_SPAN) / den;
      if (ang < 0) ang = 0;
      else if (ang > ANGLE_MAX) ang = ANGLE_MAX;
    end
    err = int'(loop_target) - ang;
    if (err > ERR_HALF) err -= ANGLE_SPAN;
    else if (err < -ERR_HALF) err += ANGLE_SPAN;
    drv = DRIVE_STOP - err;
    if (drv < 0) drv = 0;
    else if (drv > DRIVE_MAX) drv = DRIVE_MAX;
    cmd.drive = drv[DRIVE_W-1:0];
    cmd.angle = ang[ANGLE_W-1:0];
    cmd.err   = err[ANGLE_W-1:0];
    return 1'b1;
  endfunction

  // Input side monitor: predict on every accepted pulse word, and track
  // register writes so the shadow copy follows the DUT.
  always @(posedge clk) begin
    servo_cmd_t cmd;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pulses_sent <= pulses_sent + 1;
        if (servo_command_of(high_time, low_time, cmd)) begin
          pending_cmds.push_back(cmd);
          kept_pulses <= kept_pulses + 1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (fspl_reg_t'(cfg_index))
          REG_TARGET_ANGLE: loop_target = cfg_data[ANGLE_W-1:0];
          REG_PERIOD_MIN:   win_lo      = cfg_data[PMIN_W-1:0];
          REG_PERIOD_MAX:   win_hi      = cfg_data[PMIN_W-1:0];
          REG_DUTY_MIN:     duty_lo     = cfg_data[DUTY_W-1:0];
          REG_DUTY_MAX:     duty_hi     = cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Output side: every accepted command word against the oldest prediction.
  always @(posedge clk) begin
    servo_cmd_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        orphan_cmds <= orphan_cmds + 1;
        if (mismatches + orphan_cmds < MAX_REPORTS)
          $display("unexpected word: drive=%0d angle=%0d error=%0d",
                   drive, measured_angle, angle_error);
      end else begin
        want = pending_cmds.pop_front();
        cmds_checked <= cmds_checked + 1;
        if (drive !== want.drive || measured_angle !== want.angle ||
            angle_error !== want.err) begin
          if (mismatches + orphan_cmds < MAX_REPORTS)
            $display("mismatch: drive %0d/%0d angle %0d/%0d error %0d/%0d (exp/got)",
                     want.drive, drive, want.angle, measured_angle,
                     want.err, angle_error);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // Offer one pulse word, maybe after a random gap; returns once accepted.
  // Valid stays high on return so back-to-back words need no extra step.
  task automatic send_pulse(input logic [TIME_BITS-1:0] hi_us,
                            input logic [TIME_BITS-1:0] lo_us);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    high_time <= hi_us;
    low_time  <= lo_us;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering, let every owed command drain, then let the core settle
  // before touching the registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input fspl_reg_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(input int tgt, input int pmin, input int pmax,
                                input int dmin, input int dmax);
    wait_idle();
    write_reg(REG_TARGET_ANGLE, tgt);
    write_reg(REG_PERIOD_MIN, pmin);
    write_reg(REG_PERIOD_MAX, pmax);
    write_reg(REG_DUTY_MIN, dmin);
    write_reg(REG_DUTY_MAX, dmax);
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // Window edges at reset values (1000, 1200): both bounds exclusive,
  // zero period, and duty at both ends.
  task automatic test_window_edges();
    send_pulse(500, 500);    // exactly period_min: dropped
    send_pulse(500, 501);
    send_pulse(600, 599);
    send_pulse(600, 600);    // exactly period_max: dropped
    send_pulse(0, 0);        // zero period
    send_pulse(0, 1100);     // duty 0, angle clamps low
    send_pulse(1100, 0);     // duty 1000, angle clamps high
  endtask

  // Angle mapping and error wrap in both directions, drive saturation.
  task automatic test_angle_mapping();
    send_pulse(330, 770);    // error near -100: drive pegs at max
    send_pulse(660, 440);    // error below -180: wraps positive, drive 0
    send_pulse(540, 560);
    apply_settings(ANGLE_MAX, RST_PERIOD_MIN, RST_PERIOD_MAX,
                   RST_DUTY_MIN, RST_DUTY_MAX);
    send_pulse(0, 1100);     // error 359 wraps to -1
    send_pulse(550, 550);    // error just above 180
    send_pulse(1067, 33);
  endtask

  // Register extremes: out-of-range target, inverted duty span, full and
  // empty windows, top-of-field duty values.
  task automatic test_register_extremes();
    apply_settings(511, 0, 4095, 1000, 0);  // denominator negative
    send_pulse(4094, 0);
    send_pulse(0, 1);
    send_pulse(2047, 2047);
    send_pulse(4095, 4095);  // period over any 12-bit window
    apply_settings(0, 4095, 0, 1023, 1023); // empty window
    send_pulse(1, 1);
    send_pulse(2000, 0);
    apply_settings(360, 0, 4095, 0, 1000);
    send_pulse(4000, 94);
    send_pulse(1, 4000);
    send_pulse(2730, 1364);
  endtask

  // Random settings blocks; mostly in-window pulses, the rest raw noise.
  task automatic test_random_traffic();
    int tgt;
    int pmin;
    int pmax;
    int dmin;
    int dmax;
    int period;
    int hi_us;
    for (int b = 0; b < PHASE_BLOCKS; b++) begin
      tgt  = ($urandom_range(9) == 0) ? $urandom_range(360, 511)
                                      : $urandom_range(0, ANGLE_MAX);
      if ($urandom_range(1)) begin
        pmin = $urandom_range(0, 4093);
        pmax = $urandom_range(pmin + 2, 4095);
      end else begin
        pmin = $urandom_range(900, 1050);   // near real servo feedback
        pmax = $urandom_range(1150, 1300);
      end
      if ($urandom_range(99) < 85) begin
        dmin = $urandom_range(0, 999);
        dmax = $urandom_range(dmin + 1, 1000);
      end else begin
        dmin = $urandom_range(0, 1023);
        dmax = $urandom_range(0, 1023);
      end
      apply_settings(tgt, pmin, pmax, dmin, dmax);
      for (int n = 0; n < PULSES_PER_BLK; n++) begin
        if ($urandom_range(99) < 80) begin
          period = $urandom_range(pmin + 1, pmax - 1);
          case ($urandom_range(19))
            0:       hi_us = 0;
            1:       hi_us = period;
            default: hi_us = $urandom_range(0, period);
          endcase
          send_pulse(TIME_BITS'(hi_us), TIME_BITS'(period - hi_us));
        end else begin
          send_pulse(TIME_BITS'($urandom_range(0, 4095)),
                     TIME_BITS'($urandom_range(0, 4095)));
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender mostly busy, receiver stalls a lot
    gap_pct   = 8;
    stall_pct = 59;
    test_window_edges();
    test_angle_mapping();
    test_register_extremes();
    test_random_traffic();

    // sender sparse, receiver mostly ready
    gap_pct   = 59;
    stall_pct = 8;
    test_random_traffic();

    // full rate both ways
    gap_pct   = 0;
    stall_pct = 0;
    test_random_traffic();

    wait_idle();

    $display("%0d pulse words sent, %0d inside the window, %0d commands checked",
             pulses_sent, kept_pulses, cmds_checked);
    $display("%0d register settings applied, %0d mismatches, %0d unexpected words",
             settings_done, mismatches, orphan_cmds);
    if (mismatches == 0 && orphan_cmds == 0 && pending_cmds.size() == 0) begin
      $display("feedback_servo_position_loop_core verification clean");
    end else begin
      $display("feedback_servo_position_loop_core verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/fspl_pkg.sv
hw/rtl/fspl_front.sv
hw/rtl/fspl_fifo.sv
hw/rtl/fspl_div.sv
hw/rtl/fspl_back.sv
hw/rtl/feedback_servo_position_loop_core.sv
bench/tb_top.sv
